FILE: hdl/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_FLAGS = 3'd1,
    PH_UID   = 3'd2,
    PH_STAMP = 3'd3,
    PH_DOWN  = 3'd4,
    PH_UP    = 3'd5,
    PH_LEN   = 3'd6,
    PH_BODY  = 3'd7
  } phase_t;

  localparam logic [15:0] FLAG_UID        = 16'h0020;
  localparam logic [15:0] FLAG_STAMP      = 16'h0010;
  localparam logic [15:0] FLAG_DOWN       = 16'h0008;
  localparam logic [15:0] FLAG_UP         = 16'h0004;
  localparam logic [15:0] FLAG_ENCRYPTED  = 16'h0002;
  localparam logic [15:0] FLAG_COMPRESSED = 16'h0001;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] cmd_type;
    logic [15:0] flag_bits;
    logic [63:0] user_id;
    logic [63:0] time_stamp;
    logic [31:0] down_seq;
    logic [31:0] up_seq;
    logic [31:0] body_length;
    logic        is_deliver;
    logic [7:0]  body_byte;
    logic        last;
  } result_t;

  function automatic logic [3:0] mfd_field_len(input phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_CMD, PH_FLAGS:           n = 4'd2;
      PH_UID, PH_STAMP:           n = 4'd8;
      PH_DOWN, PH_UP, PH_LEN:     n = 4'd4;
      default:                    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic phase_t mfd_next_phase(input phase_t from, input logic [15:0] flags);
    phase_t ph;
    if (from <= PH_UID && (flags & FLAG_UID) != 16'd0) begin
      ph = PH_UID;
    end else if (from <= PH_STAMP && (flags & FLAG_STAMP) != 16'd0) begin
      ph = PH_STAMP;
    end else if (from <= PH_DOWN && (flags & FLAG_DOWN) != 16'd0) begin
      ph = PH_DOWN;
    end else if (from <= PH_UP && (flags & FLAG_UP) != 16'd0) begin
      ph = PH_UP;
    end else begin
      ph = PH_LEN;
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mfd_parser.sv
`default_nettype none

module mfd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [15:0]     cfg_wr_data,
  input  wire logic            take,
  input  wire logic [7:0]      data_byte,
  input  wire logic            restart,
  output logic                 res_valid,
  output mfd_pkg::result_t     res
);
  import mfd_pkg::*;

  logic [15:0] deliver_cmd;
  phase_t      phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [15:0] cmd, cmd_next;
  logic [15:0] flags, flags_next;
  logic [63:0] uid, uid_next;
  logic [63:0] stamp, stamp_next;
  logic [31:0] down, down_next;
  logic [31:0] up, up_next;
  logic [31:0] len, len_next;
  logic [31:0] rem, rem_next;
  logic        dlv, dlv_next;
  logic [3:0]  cnt_inc;
  logic        field_done;
  logic        hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      deliver_cmd <= 16'd0;
    end else if (cfg_wr_en) begin
      deliver_cmd <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CMD;
      cnt   <= 4'd0;
      rem   <= 32'd0;
      dlv   <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      dlv   <= dlv_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    flags <= flags_next;
    uid   <= uid_next;
    stamp <= stamp_next;
    down  <= down_next;
    up    <= up_next;
    len   <= len_next;
  end

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    cmd_next   = cmd;
    flags_next = flags;
    uid_next   = uid;
    stamp_next = stamp;
    down_next  = down;
    up_next    = up;
    len_next   = len;
    rem_next   = rem;
    dlv_next   = dlv;
    cnt_inc    = cnt + 4'd1;
    field_done = cnt_inc == mfd_field_len(phase);
    hit        = cmd == deliver_cmd;

    res_valid       = 1'b0;
    res.kind        = KIND_HEADER;
    res.cmd_type    = cmd;
    res.flag_bits   = flags;
    res.user_id     = uid;
    res.time_stamp  = stamp;
    res.down_seq    = down;
    res.up_seq      = up;
    res.body_length = len;
    res.is_deliver  = hit;
    res.body_byte   = 8'd0;
    res.last        = 1'b0;

    if (take) begin
      if (restart) begin
        phase_next = PH_CMD;
        cnt_next   = 4'd0;
        rem_next   = 32'd0;
      end else if (phase == PH_BODY) begin
        rem_next = rem - 32'd1;
        if (rem == 32'd1) begin
          phase_next = PH_CMD;
          cnt_next   = 4'd0;
        end
        if (dlv) begin
          res_valid      = 1'b1;
          res.kind       = KIND_BODY;
          res.is_deliver = 1'b1;
          res.body_byte  = data_byte;
          res.last       = rem == 32'd1;
        end
      end else begin
        cnt_next = field_done ? 4'd0 : cnt_inc;
        case (phase)
          PH_CMD:   cmd_next   = {cmd[7:0], data_byte};
          PH_FLAGS: flags_next = {flags[7:0], data_byte};
          PH_UID:   uid_next   = {uid[55:0], data_byte};
          PH_STAMP: stamp_next = {stamp[55:0], data_byte};
          PH_DOWN:  down_next  = {down[23:0], data_byte};
          PH_UP:    up_next    = {up[23:0], data_byte};
          default:  len_next   = {len[23:0], data_byte};
        endcase
        if (field_done) begin
          unique case (phase)
            PH_CMD: begin
              phase_next = PH_FLAGS;
            end
            PH_FLAGS: begin
              uid_next   = 64'd0;
              stamp_next = 64'd0;
              down_next  = 32'd0;
              up_next    = 32'd0;
              len_next   = 32'd0;
              phase_next = mfd_next_phase(PH_UID, flags_next);
            end
            PH_UID, PH_STAMP, PH_DOWN, PH_UP: begin
              phase_next = mfd_next_phase(phase_t'(phase + 3'd1), flags);
            end
            default: begin
              res_valid       = 1'b1;
              res.body_length = len_next;
              res.last        = (len_next == 32'd0) || !hit;
              if (len_next == 32'd0) begin
                phase_next = PH_CMD;
              end else begin
                phase_next = PH_BODY;
                rem_next   = len_next;
                dlv_next   = hit;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mfd_out_buf.sv
`default_nettype none

module mfd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mfd_pkg::result_t  din,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mfd_pkg::result_t       dout
);
  import mfd_pkg::*;

  logic [1:0] count, count_next;
  result_t    s0, s1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign dout      = s0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (pop && count == 2'd1))) begin
      s0 <= din;
    end else if (pop) begin
      s0 <= s1;
    end
    if (push && !pop && count == 2'd1) begin
      s1 <= din;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("result pushed into full buffer");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1)
    else $error("buffer count did not drop on pop");
`endif

endmodule

`default_nettype wire

FILE: hdl/message_frame_deframer.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     data_byte, restart
// out      out_valid / out_ready   kind .. last (one per header, one per delivered body byte)
// cfg      cfg_wr_en               cfg_wr_data -> deliver_cmd
//
// One byte per cycle while in_ready is high; the parser updates its state in the cycle the byte is taken.
// A result is pushed into the result buffer as its byte is accepted and is held there from the next cycle.
// A two-entry result buffer keeps in_ready high while one result waits.
// in_ready drops only when both buffer entries are held.
// Reset is synchronous: parser returns to the command field, deliver_cmd to 0.
`default_nettype none

module message_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [15:0]      cmd_type,
  output logic [15:0]      flag_bits,
  output logic [63:0]      user_id,
  output logic [63:0]      time_stamp,
  output logic [31:0]      down_seq,
  output logic [31:0]      up_seq,
  output logic [31:0]      body_length,
  output logic             is_deliver,
  output logic [7:0]       body_byte,
  output logic             last
);
  import mfd_pkg::*;

  logic    take;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t dout;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  mfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .data_byte   (data_byte),
    .restart     (restart),
    .res_valid   (res_valid),
    .res         (res)
  );

  mfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign kind        = dout.kind;
  assign cmd_type    = dout.cmd_type;
  assign flag_bits   = dout.flag_bits;
  assign user_id     = dout.user_id;
  assign time_stamp  = dout.time_stamp;
  assign down_seq    = dout.down_seq;
  assign up_seq      = dout.up_seq;
  assign body_length = dout.body_length;
  assign is_deliver  = dout.is_deliver;
  assign body_byte   = dout.body_byte;
  assign last        = dout.last;

endmodule

`default_nettype wire
